// ===== rtl/fcnt_pkg.sv =====
// shared types, constants and hash functions for the five-tuple flow counter
// no dependencies
`default_nettype none

package fcnt_pkg;

	localparam int unsigned MAC_W       = 48;
	localparam int unsigned IP_W        = 32;
	localparam int unsigned PORT_W      = 16;
	localparam int unsigned PROTO_W     = 8;
	localparam int unsigned KEY_HIGH_W  = 64;
	localparam int unsigned KEY_LOW_W   = 40;
	localparam int unsigned COUNT_W     = 64;
	localparam int unsigned STREAM_W    = 128;
	localparam int unsigned STATUS_W    = 2;
	localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_LOW_W-1:0]  key_low;
	} key_t;

	typedef struct packed {
		logic                  valid;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [KEY_LOW_W-1:0]  key_low;
		logic [COUNT_W-1:0]    count;
	} entry_t;

	typedef struct packed {
		logic adv;
		logic valid_s3;
		logic valid_s4;
	} pipe_ctl_t;

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] count;
	} lookup_res_t;

	function automatic logic [31:0] crc32c_step(input logic [31:0] c);
		return (c >> 1) ^ (c[0] ? CRC32C_POLY : 32'h0);
	endfunction

	// contribution of one stream bit to the crc (zero initial value, so the crc is linear)
	function automatic logic [31:0] crc32c_col(input int unsigned pos);
		logic [31:0] c;
		c = 32'h1;
		for (int unsigned n = 0; n < STREAM_W; n++) begin
			if (n >= pos) begin
				c = crc32c_step(c);
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] crc32c_stream(input logic [STREAM_W-1:0] s);
		logic [31:0] h;
		h = 32'h0;
		for (int unsigned i = 0; i < STREAM_W; i++) begin
			if (s[i]) begin
				h = h ^ crc32c_col(i);
			end
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/five_tuple_flow_counter_unit.sv =====
// top level of the five-tuple flow counter: request and result channels, pipeline control
// depends on fcnt_pkg, fcnt_hash, fcnt_table
//
// A request carries one packet header: both MAC addresses and the IPv4 5-tuple.
// Each request gives exactly one result: the MACs swapped, a status (flow counted,
// new flow inserted, bucket full) and the flow's 64-bit count after this packet.
// Both channels move an item at an edge where valid is high and stall is low.
// A request passes the stage registers s1 to s4 and then the output register.
// Throughput: one request per cycle while pkt_stall is low, also for back-to-back packets of one flow;
// each request makes one read and at most one write of a whole bucket row in the
// bucket memory, with the row forwarded when the next request hits the same bucket.
// After reset the bucket memory is cleared one bucket per cycle, all TABLE_ENTRIES /
// BUCKET_WAYS buckets (128 by default); pkt_stall stays high during that pass.
// When res_stall holds a waiting result, the whole pipeline holds and pkt_stall
// rises in the same cycle; nothing is dropped.
`default_nettype none

module five_tuple_flow_counter_unit
	import fcnt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 1024,
	parameter int unsigned BUCKET_WAYS   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pkt_valid,
	output logic                    pkt_stall,
	input  wire logic [MAC_W-1:0]   dest_mac,
	input  wire logic [MAC_W-1:0]   source_mac,
	input  wire logic [IP_W-1:0]    source_ip,
	input  wire logic [IP_W-1:0]    dest_ip,
	input  wire logic [PORT_W-1:0]  source_port,
	input  wire logic [PORT_W-1:0]  dest_port,
	input  wire logic [PROTO_W-1:0] protocol,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [MAC_W-1:0]        out_dest_mac,
	output logic [MAC_W-1:0]        out_source_mac,
	output logic [STATUS_W-1:0]     status,
	output logic [COUNT_W-1:0]      flow_count
);

	localparam int unsigned BUCKET_COUNT = TABLE_ENTRIES / BUCKET_WAYS;
	localparam int unsigned IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

	logic               adv;
	logic               accept;
	logic               busy;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	logic [MAC_W-1:0]   dmac_s1;
	logic [MAC_W-1:0]   dmac_s2;
	logic [MAC_W-1:0]   dmac_s3;
	logic [MAC_W-1:0]   dmac_s4;
	logic [MAC_W-1:0]   smac_s1;
	logic [MAC_W-1:0]   smac_s2;
	logic [MAC_W-1:0]   smac_s3;
	logic [MAC_W-1:0]   smac_s4;
	key_t               pkt_key;
	key_t               key_s3;
	logic [IDX_W-1:0]   idx_s3;
	pipe_ctl_t          ctl;
	lookup_res_t        res_s4;
	logic               res_valid_q;
	logic [MAC_W-1:0]   out_dest_mac_q;
	logic [MAC_W-1:0]   out_source_mac_q;
	status_t            status_q;
	logic [COUNT_W-1:0] flow_count_q;

	assign adv       = !(res_valid_q && res_stall);
	assign pkt_stall = busy || !adv;
	assign accept    = pkt_valid && !pkt_stall;

	assign pkt_key.key_high = {source_ip, dest_ip};
	assign pkt_key.key_low  = {source_port, dest_port, protocol};

	assign ctl.adv      = adv;
	assign ctl.valid_s3 = valid_s3;
	assign ctl.valid_s4 = valid_s4;

	fcnt_hash #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.IDX_W       (IDX_W)
	) u_hash (
		.clk   (clk),
		.adv   (adv),
		.key_in(pkt_key),
		.key_s3(key_s3),
		.idx_s3(idx_s3)
	);

	fcnt_table #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.BUCKET_WAYS (BUCKET_WAYS),
		.IDX_W       (IDX_W)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.key_s3(key_s3),
		.idx_s3(idx_s3),
		.res_s4(res_s4),
		.busy  (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			res_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dmac_s1          <= dest_mac;
			smac_s1          <= source_mac;
			dmac_s2          <= dmac_s1;
			smac_s2          <= smac_s1;
			dmac_s3          <= dmac_s2;
			smac_s3          <= smac_s2;
			dmac_s4          <= dmac_s3;
			smac_s4          <= smac_s3;
			out_dest_mac_q   <= smac_s4;
			out_source_mac_q <= dmac_s4;
			status_q         <= res_s4.status;
			flow_count_q     <= res_s4.count;
		end
	end

	assign res_valid      = res_valid_q;
	assign out_dest_mac   = out_dest_mac_q;
	assign out_source_mac = out_source_mac_q;
	assign status         = status_q;
	assign flow_count     = flow_count_q;

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(valid_s1 || valid_s2 || valid_s3 || valid_s4))
		else $error("request in flight during table clearing");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status_q == ST_NEW || status_q == ST_FULL) |-> flow_count == '0)
		else $error("nonzero count on new flow or full bucket");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s4 |=> res_valid)
		else $error("lookup result lost on the way to the output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s4) && $stable(idx_s3))
		else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

// ===== rtl/fcnt_hash.sv =====
// crc32c of the flow key and reduction to a bucket index, three pipeline stages
// depends on fcnt_pkg
`default_nettype none

module fcnt_hash
	import fcnt_pkg::*;
#(
	parameter int unsigned BUCKET_COUNT = 128,
	parameter int unsigned IDX_W        = 7
) (
	input  wire logic             clk,
	input  wire logic             adv,
	input  wire key_t             key_in,
	output key_t                  key_s3,
	output logic [IDX_W-1:0]      idx_s3
);

	localparam bit IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

	logic [31:0] crc_s1;
	logic [31:0] crc_s2;
	key_t        key_s1;
	key_t        key_s2;
	logic [STREAM_W-1:0] stream;

	// hashing order: source ip, dest ip, source port, dest port, protocol as 32 bits
	assign stream = {24'h0, key_in.key_low[7:0], key_in.key_low[23:8],
		key_in.key_low[39:24], key_in.key_high[31:0], key_in.key_high[63:32]};

	always_ff @(posedge clk) begin
		if (adv) begin
			crc_s1 <= crc32c_stream(stream);
			key_s1 <= key_in;
			crc_s2 <= crc_s1;
			key_s2 <= key_s1;
			key_s3 <= key_s2;
		end
	end

	generate
		if (IS_POW2) begin : g_mask
			logic [IDX_W-1:0] idx_q;
			always_ff @(posedge clk) begin
				if (adv) begin
					idx_q <= IDX_W'(crc_s2 & 32'(BUCKET_COUNT - 1));
				end
			end
			assign idx_s3 = idx_q;
		end else begin : g_recip
			localparam int unsigned REM_W = IDX_W + 1;
			localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / BUCKET_COUNT);
			logic [63:0]      prod_s2;
			logic [REM_W-1:0] rem_s3;
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s2 <= 64'(crc_s1) * 64'(RECIP);
					rem_s3  <= REM_W'(crc_s2 - 32'(prod_s2[63:32] * 32'(BUCKET_COUNT)));
				end
			end
			// quotient estimate is low by at most one
			assign idx_s3 = (rem_s3 >= REM_W'(BUCKET_COUNT)) ?
				IDX_W'(rem_s3 - REM_W'(BUCKET_COUNT)) : IDX_W'(rem_s3);
		end
	endgenerate

endmodule

`default_nettype wire

// ===== rtl/fcnt_table.sv =====
// bucket memory with clearing pass, read-modify-write of one bucket per request
// depends on fcnt_pkg
`default_nettype none

module fcnt_table
	import fcnt_pkg::*;
#(
	parameter int unsigned BUCKET_COUNT = 128,
	parameter int unsigned BUCKET_WAYS  = 8,
	parameter int unsigned IDX_W        = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pipe_ctl_t        ctl,
	input  wire key_t             key_s3,
	input  wire logic [IDX_W-1:0] idx_s3,
	output lookup_res_t           res_s4,
	output logic                  busy
);

	localparam int unsigned WAY_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

	entry_t [BUCKET_WAYS-1:0] bucket_q [BUCKET_COUNT];

	entry_t [BUCKET_WAYS-1:0] rd_row_s4;
	entry_t [BUCKET_WAYS-1:0] fwd_row_s4;
	entry_t [BUCKET_WAYS-1:0] row;
	entry_t [BUCKET_WAYS-1:0] new_row;
	entry_t [BUCKET_WAYS-1:0] wr_row;
	logic                     fwd_s4;
	logic [IDX_W-1:0]         idx_s4;
	key_t                     key_s4;
	logic                     busy_q;
	logic [IDX_W-1:0]         clr_idx_q;
	logic                     hit_any;
	logic                     free_any;
	logic [WAY_W-1:0]         hit_way;
	logic [WAY_W-1:0]         free_way;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_idx;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == IDX_W'(BUCKET_COUNT - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s4 <= 1'b0;
		end else if (ctl.adv) begin
			fwd_s4 <= ctl.valid_s3 && ctl.valid_s4 && (idx_s3 == idx_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rd_row_s4  <= bucket_q[idx_s3];
			fwd_row_s4 <= new_row;
			idx_s4     <= idx_s3;
			key_s4     <= key_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bucket_q[wr_idx] <= wr_row;
		end
	end

	// bucket written back in the same cycle as this read
	assign row = fwd_s4 ? fwd_row_s4 : rd_row_s4;

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int unsigned w = 0; w < BUCKET_WAYS; w++) begin
			if (row[w].valid && row[w].key_high == key_s4.key_high &&
					row[w].key_low == key_s4.key_low) begin
				if (!hit_any) begin
					hit_any = 1'b1;
					hit_way = WAY_W'(w);
				end
			end else if (!row[w].valid && !free_any) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		new_row       = row;
		res_s4.status = ST_FULL;
		res_s4.count  = '0;
		if (hit_any) begin
			res_s4.count           = row[hit_way].count + 64'd1;
			new_row[hit_way].count = row[hit_way].count + 64'd1;
			res_s4.status          = ST_HIT;
		end else if (free_any) begin
			new_row[free_way].valid    = 1'b1;
			new_row[free_way].key_high = key_s4.key_high;
			new_row[free_way].key_low  = key_s4.key_low;
			new_row[free_way].count    = '0;
			res_s4.status              = ST_NEW;
		end
	end

	assign wr_en  = busy_q || (ctl.adv && ctl.valid_s4 && (hit_any || free_any));
	assign wr_idx = busy_q ? clr_idx_q : idx_s4;
	assign wr_row = busy_q ? '0 : new_row;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for five_tuple_flow_counter_unit: a driver and a monitor
// with random idle and stall bursts, checked against a flow table kept in the bench
// depends on fcnt_pkg and the rtl of five_tuple_flow_counter_unit
`default_nettype none

module testbench;
	import fcnt_pkg::*;

	localparam int ENTRIES      = 1024;
	localparam int WAYS         = 8;
	localparam int BUCKETS      = ENTRIES / WAYS;
	localparam int RANDOM_REQS  = 1900;
	localparam int CALM_TAIL    = 120;

	typedef struct packed {
		logic               drain;
		logic [MAC_W-1:0]   dmac;
		logic [MAC_W-1:0]   smac;
		logic [IP_W-1:0]    sip;
		logic [IP_W-1:0]    dip;
		logic [PORT_W-1:0]  sp;
		logic [PORT_W-1:0]  dp;
		logic [PROTO_W-1:0] proto;
	} req_t;

	typedef struct packed {
		logic [MAC_W-1:0]   dmac;
		logic [MAC_W-1:0]   smac;
		status_t            st;
		logic [COUNT_W-1:0] count;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pkt_valid = 1'b0;
	logic pkt_stall;
	logic [MAC_W-1:0] dest_mac = '0;
	logic [MAC_W-1:0] source_mac = '0;
	logic [IP_W-1:0] source_ip = '0;
	logic [IP_W-1:0] dest_ip = '0;
	logic [PORT_W-1:0] source_port = '0;
	logic [PORT_W-1:0] dest_port = '0;
	logic [PROTO_W-1:0] protocol = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [MAC_W-1:0] out_dest_mac;
	logic [MAC_W-1:0] out_source_mac;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] flow_count;

	five_tuple_flow_counter_unit #(
		.TABLE_ENTRIES(ENTRIES),
		.BUCKET_WAYS(WAYS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.dest_mac(dest_mac),
		.source_mac(source_mac),
		.source_ip(source_ip),
		.dest_ip(dest_ip),
		.source_port(source_port),
		.dest_port(dest_port),
		.protocol(protocol),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_dest_mac(out_dest_mac),
		.out_source_mac(out_source_mac),
		.status(status),
		.flow_count(flow_count)
	);

	// flow table mirror
	logic                  slot_used [ENTRIES];
	logic [KEY_HIGH_W-1:0] slot_key_hi [ENTRIES];
	logic [KEY_LOW_W-1:0]  slot_key_lo [ENTRIES];
	logic [COUNT_W-1:0]    slot_hits [ENTRIES];

	req_t     req_q [$];
	verdict_t verdict_q [$];
	req_t     cur_req;
	verdict_t want;

	int n_hit = 0;
	int n_new = 0;
	int n_full = 0;
	int n_drain = 0;
	int sent = 0;
	int results = 0;
	int mismatches = 0;
	int idle_left = 0;
	int stall_left = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	always #2 clk = ~clk;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int flow_bucket(input req_t p);
		logic [127:0] stream;
		logic [31:0] crc;
		logic fb;
		int i;
		stream = {24'h0, p.proto, p.dp, p.sp, p.dip, p.sip};
		crc = 32'h0;
		for (i = 0; i < 128; i++) begin
			fb = crc[0] ^ stream[i];
			crc = (crc >> 1) ^ (fb ? CRC32C_POLY : 32'h0);
		end
		return int'(crc % BUCKETS);
	endfunction

	function automatic verdict_t count_packet(input req_t p);
		verdict_t v;
		logic [KEY_HIGH_W-1:0] khi;
		logic [KEY_LOW_W-1:0] klo;
		int base;
		int free_way;
		int w;
		logic found;
		khi = {p.sip, p.dip};
		klo = {p.sp, p.dp, p.proto};
		base = flow_bucket(p) * WAYS;
		free_way = -1;
		found = 1'b0;
		v.dmac = p.smac;
		v.smac = p.dmac;
		v.st = ST_FULL;
		v.count = '0;
		for (w = 0; w < WAYS; w++) begin
			if (!found) begin
				if (slot_used[base + w]) begin
					if (slot_key_hi[base + w] == khi && slot_key_lo[base + w] == klo) begin
						slot_hits[base + w] = slot_hits[base + w] + 1'b1;
						v.count = slot_hits[base + w];
						v.st = ST_HIT;
						found = 1'b1;
					end
				end else if (free_way < 0) begin
					free_way = w;
				end
			end
		end
		if (!found && free_way >= 0) begin
			slot_used[base + free_way] = 1'b1;
			slot_key_hi[base + free_way] = khi;
			slot_key_lo[base + free_way] = klo;
			slot_hits[base + free_way] = '0;
			v.st = ST_NEW;
		end
		case (v.st)
			ST_HIT: n_hit++;
			ST_NEW: n_new++;
			default: n_full++;
		endcase
		return v;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(3))
			0, 1: return 0;
			2: return 8;
			default: return 30;
		endcase
	endfunction

	// mostly random, now and then all zeros or all ones
	function automatic logic [47:0] spread(input int bits);
		logic [63:0] r;
		logic [47:0] m;
		m = (48'h1 << bits) - 48'h1;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return '0;
			1: return m;
			default: return r[47:0] & m;
		endcase
	endfunction

	function automatic req_t fresh_flow();
		req_t p;
		p = '0;
		p.dmac = spread(48);
		p.smac = spread(48);
		p.sip = 32'(spread(32));
		p.dip = 32'(spread(32));
		p.sp = 16'(spread(16));
		p.dp = 16'(spread(16));
		p.proto = 8'(spread(8));
		return p;
	endfunction

	function automatic req_t flow_in_bucket(input int b);
		req_t p;
		p = fresh_flow();
		while (flow_bucket(p) != b) begin
			p = fresh_flow();
		end
		return p;
	endfunction

	function automatic req_t twist(input req_t p);
		logic [103:0] k;
		int b;
		k = {p.sip, p.dip, p.sp, p.dp, p.proto};
		b = $urandom_range(103);
		k[b] = ~k[b];
		{p.sip, p.dip, p.sp, p.dp, p.proto} = k;
		return p;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_valid && !pkt_stall) begin
				cur_req = req_q.pop_front();
				verdict_q.push_back(count_packet(cur_req));
				sent++;
				if (sent % 50 == 0) begin
					idle_pct = pick_pct();
				end
			end
			if (!pkt_valid || !pkt_stall) begin
				if (idle_left > 0) begin
					pkt_valid <= 1'b0;
					idle_left--;
				end else if (req_q.size() == 0) begin
					pkt_valid <= 1'b0;
				end else if (req_q[0].drain) begin
					pkt_valid <= 1'b0;
					if (verdict_q.size() == 0) begin
						cur_req = req_q.pop_front();
						n_drain++;
					end
				end else if (req_q.size() > CALM_TAIL && $urandom_range(99) < idle_pct) begin
					pkt_valid <= 1'b0;
					idle_left = $urandom_range(14);
				end else begin
					pkt_valid <= 1'b1;
					dest_mac <= req_q[0].dmac;
					source_mac <= req_q[0].smac;
					source_ip <= req_q[0].sip;
					dest_ip <= req_q[0].dip;
					source_port <= req_q[0].sp;
					dest_port <= req_q[0].dp;
					protocol <= req_q[0].proto;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: result with no request pending, status %0d count %0d",
						$time, status, flow_count);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					if (out_dest_mac !== want.dmac) begin
						$display("%0t: out_dest_mac expected %h actual %h",
							$time, want.dmac, out_dest_mac);
						mismatches++;
					end
					if (out_source_mac !== want.smac) begin
						$display("%0t: out_source_mac expected %h actual %h",
							$time, want.smac, out_source_mac);
						mismatches++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						mismatches++;
					end
					if (flow_count !== want.count) begin
						$display("%0t: flow_count expected %0d actual %0d",
							$time, want.count, flow_count);
						mismatches++;
					end
				end
				results++;
				if (results % 50 == 0) begin
					stall_pct = pick_pct();
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (req_q.size() > CALM_TAIL && $urandom_range(99) < stall_pct) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(14);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		req_t p;
		req_t flow_pool [$];
		int k;
		int gen;
		int roll;
		int reps;
		int hot;
		int next_drain;

		// directed: extremes, repeats, protocol split, full bucket
		p = '0;
		req_q.push_back(p);
		p.dmac = '1;
		p.smac = '1;
		req_q.push_back(p);
		p.dmac = 48'hAAAA_AAAA_AAAA;
		p.smac = 48'h5555_5555_5555;
		req_q.push_back(p);
		p = '1;
		p.drain = 1'b0;
		req_q.push_back(p);
		p.dmac = 48'h0000_0000_0001;
		p.smac = 48'h8000_0000_0000;
		req_q.push_back(p);
		p = '0;
		p.sip = 32'h0100_000a;
		p.dip = 32'h0200_000a;
		p.sp = 16'h5000;
		p.dp = 16'h3500;
		p.proto = 8'd6;
		req_q.push_back(p);
		p.proto = 8'd17;
		req_q.push_back(p);
		p.proto = 8'd6;
		req_q.push_back(p);
		for (k = 0; k < WAYS; k++) begin
			p = flow_in_bucket(0);
			req_q.push_back(p);
			if (k == WAYS - 1) begin
				req_q.push_back(p);
			end
		end
		p = '0;
		req_q.push_back(p);
		p.drain = 1'b1;
		req_q.push_back(p);

		// random: mostly repeats of known flows, new flows, crowded buckets
		gen = 0;
		hot = 0;
		next_drain = 650;
		while (gen < RANDOM_REQS) begin
			if (gen >= next_drain) begin
				p = '0;
				p.drain = 1'b1;
				req_q.push_back(p);
				next_drain += 650;
			end
			if (gen % 150 == 0) begin
				hot = $urandom_range(BUCKETS - 1);
			end
			roll = $urandom_range(99);
			if (roll < 50 && flow_pool.size() > 0) begin
				p = flow_pool[$urandom_range(flow_pool.size() - 1)];
				reps = ($urandom_range(3) == 0) ? $urandom_range(6, 2) : 1;
				for (k = 0; k < reps; k++) begin
					p.dmac = spread(48);
					p.smac = spread(48);
					req_q.push_back(p);
					gen++;
				end
			end else begin
				if (roll < 75) begin
					p = fresh_flow();
				end else if (roll < 88) begin
					p = flow_in_bucket(hot);
				end else if (flow_pool.size() > 0) begin
					p = twist(flow_pool[$urandom_range(flow_pool.size() - 1)]);
				end else begin
					p = fresh_flow();
				end
				req_q.push_back(p);
				gen++;
				if (flow_pool.size() < 400) begin
					flow_pool.push_back(p);
				end
			end
		end

		while (req_q.size() > 0 || verdict_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
		if (verdict_q.size() != 0) begin
			mismatches++;
		end
		$display("%0d requests checked: %0d counted hits, %0d new flows, %0d bucket-full rejects",
			sent, n_hit, n_new, n_full);
		$display("%0d pauses until drained, random idle and stall bursts on both channels",
			n_drain);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d requests sent and %0d results seen", sent, results);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
